FILE: sv/lhs_pkg.sv
// ----------------------------------------------------------------------------
// lhs_pkg
// Shared types and constants of the linear-probing hash set: table geometry,
// operation and status codes, controller states and compare-unit flags.
// ----------------------------------------------------------------------------
`default_nettype none

package lhs_pkg;

  // The slot count must be a power of two so that the home slot is a mask.
  localparam int TableSlots = 1024;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int KeyW       = 64;
  localparam int SlotFieldW = 10;
  localparam int StatusW    = 3;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableSlots - 1);

  typedef enum logic {
    KindInsert = 1'b0,
    KindFind   = 1'b1
  } lhs_kind_e;

  typedef enum logic [StatusW-1:0] {
    StatInserted = 3'd0,
    StatFull     = 3'd1,
    StatFound    = 3'd2,
    StatNotFound = 3'd3,
    StatReserved = 3'd4
  } lhs_status_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StProbe,
    StReply
  } lhs_state_e;

  typedef struct packed {
    logic hit;
    logic empty;
  } lhs_flags_t;

endpackage

`default_nettype wire

FILE: sv/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing hash set of nonzero 64-bit keys with linear probing, built
// from a single-port slot RAM, a compare unit and a probe sequencer.
//
//   Channel   Direction   Handshake                  Payload
//   in        input       in_valid_i / in_ready_o    kind_i, key_i
//   out       output      out_valid_o / out_ready_i  status_o, slot_o
//
// After reset the slot RAM is cleared one slot per cycle; no item is accepted
// until every slot is clear.
// An item that probes visits k slots (1 to 1024), and the single RAM port
// reads one slot per cycle.
// A reserved key or a full-table insert skips the probe.
// The result register lets the next item start while a result waits; a
// stalled output holds the block in its reply step.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_set (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           kind_i,
  input  wire logic [lhs_pkg::KeyW-1:0]       key_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [lhs_pkg::StatusW-1:0]    status_o,
  output logic      [lhs_pkg::SlotFieldW-1:0] slot_o
);

  logic                       ram_en;
  logic                       ram_we;
  logic [lhs_pkg::SlotW-1:0]  ram_addr;
  logic [lhs_pkg::KeyW-1:0]   ram_wdata;
  logic [lhs_pkg::KeyW-1:0]   ram_rdata;
  logic [lhs_pkg::KeyW-1:0]   search_key;
  lhs_pkg::lhs_flags_t        flags;

  lhs_ram #(
    .Width(lhs_pkg::KeyW),
    .Depth(lhs_pkg::TableSlots)
  ) u_slots (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  lhs_cmp u_cmp (
    .slot_word_i(ram_rdata),
    .key_i      (search_key),
    .flags_o    (flags)
  );

  lhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .slot_o     (slot_o),
    .ram_en_o   (ram_en),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .key_o      (search_key),
    .flags_i    (flags)
  );

endmodule

`default_nettype wire

FILE: sv/lhs_ram.sv
// ----------------------------------------------------------------------------
// lhs_ram
// Generic single-port RAM with one read or write per cycle and a registered
// read data output.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/lhs_cmp.sv
// ----------------------------------------------------------------------------
// lhs_cmp
// Probe compare unit: checks the slot word just read against the search key
// and against the empty mark.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_cmp (
  input  wire logic [lhs_pkg::KeyW-1:0] slot_word_i,
  input  wire logic [lhs_pkg::KeyW-1:0] key_i,
  output lhs_pkg::lhs_flags_t           flags_o
);

  assign flags_o.hit   = (slot_word_i == key_i);
  assign flags_o.empty = (slot_word_i == '0);

endmodule

`default_nettype wire

FILE: sv/lhs_ctrl.sv
// ----------------------------------------------------------------------------
// lhs_ctrl
// Probe sequencer: clears the slot store after reset, walks the probe chain
// one slot per cycle through the RAM port and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [lhs_pkg::KeyW-1:0]     key_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [lhs_pkg::StatusW-1:0]  status_o,
  output logic      [lhs_pkg::SlotFieldW-1:0] slot_o,
  output logic                              ram_en_o,
  output logic                              ram_we_o,
  output logic      [lhs_pkg::SlotW-1:0]    ram_addr_o,
  output logic      [lhs_pkg::KeyW-1:0]     ram_wdata_o,
  output logic      [lhs_pkg::KeyW-1:0]     key_o,
  input  wire lhs_pkg::lhs_flags_t          flags_i
);

  lhs_pkg::lhs_state_e state_q, state_d;

  logic [lhs_pkg::SlotW-1:0]      pos_q, pos_d;
  logic [lhs_pkg::SlotW-1:0]      probe_q, probe_d;
  logic [lhs_pkg::SlotW-1:0]      count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  logic [lhs_pkg::KeyW-1:0]       key_q, key_d;
  lhs_pkg::lhs_kind_e             kind_q, kind_d;
  lhs_pkg::lhs_status_e           res_status_q, res_status_d;
  logic [lhs_pkg::SlotW-1:0]      res_slot_q, res_slot_d;
  lhs_pkg::lhs_status_e           out_status_q, out_status_d;
  logic [lhs_pkg::SlotFieldW-1:0] out_slot_q, out_slot_d;

  logic                      accept;
  logic                      done;
  logic                      last_probe;
  logic [lhs_pkg::SlotW-1:0] home;
  logic [lhs_pkg::SlotW-1:0] next_pos;

  assign in_ready_o = (state_q == lhs_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign home       = key_i[lhs_pkg::SlotW-1:0];
  assign next_pos   = (pos_q == lhs_pkg::LastSlot) ? '0 : pos_q + 1'b1;
  assign last_probe = (probe_q == lhs_pkg::LastSlot);

  // A probe ends on an empty slot, on a match for a find, or after a full lap.
  always_comb begin
    if (kind_q == lhs_pkg::KindInsert) begin
      done = flags_i.empty || last_probe;
    end else begin
      done = flags_i.hit || flags_i.empty || last_probe;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lhs_pkg::StClear: begin
        if (pos_q == lhs_pkg::LastSlot) begin
          state_d = lhs_pkg::StIdle;
        end
      end
      lhs_pkg::StIdle: begin
        if (accept) begin
          if (key_i == '0) begin
            state_d = lhs_pkg::StReply;
          end else if (kind_i == lhs_pkg::KindInsert && count_q == lhs_pkg::LastSlot) begin
            state_d = lhs_pkg::StReply;
          end else begin
            state_d = lhs_pkg::StProbe;
          end
        end
      end
      lhs_pkg::StProbe: begin
        if (done) begin
          state_d = lhs_pkg::StReply;
        end
      end
      lhs_pkg::StReply: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = lhs_pkg::StIdle;
        end
      end
      default: state_d = lhs_pkg::StIdle;
    endcase
  end

  always_comb begin
    pos_d        = pos_q;
    probe_d      = probe_q;
    count_d      = count_q;
    key_d        = key_q;
    kind_d       = kind_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_en_o     = 1'b0;
    ram_we_o     = 1'b0;
    ram_addr_o   = pos_q;
    ram_wdata_o  = key_q;

    unique case (state_q)
      lhs_pkg::StClear: begin
        ram_en_o    = 1'b1;
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        pos_d       = next_pos;
      end
      lhs_pkg::StIdle: begin
        if (accept) begin
          key_d      = key_i;
          kind_d     = lhs_pkg::lhs_kind_e'(kind_i);
          pos_d      = home;
          probe_d    = '0;
          res_slot_d = '0;
          if (key_i == '0) begin
            res_status_d = lhs_pkg::StatReserved;
          end else if (kind_i == lhs_pkg::KindInsert && count_q == lhs_pkg::LastSlot) begin
            res_status_d = lhs_pkg::StatFull;
          end else begin
            // Start the first read at the home slot.
            ram_en_o   = 1'b1;
            ram_addr_o = home;
          end
        end
      end
      lhs_pkg::StProbe: begin
        if (kind_q == lhs_pkg::KindInsert) begin
          if (flags_i.empty) begin
            ram_en_o     = 1'b1;
            ram_we_o     = 1'b1;
            count_d      = count_q + 1'b1;
            res_status_d = lhs_pkg::StatInserted;
            res_slot_d   = pos_q;
          end else if (last_probe) begin
            res_status_d = lhs_pkg::StatFull;
          end
        end else begin
          if (flags_i.hit) begin
            res_status_d = lhs_pkg::StatFound;
            res_slot_d   = pos_q;
          end else if (flags_i.empty || last_probe) begin
            res_status_d = lhs_pkg::StatNotFound;
          end
        end
        if (!done) begin
          ram_en_o   = 1'b1;
          ram_addr_o = next_pos;
          pos_d      = next_pos;
          probe_d    = probe_q + 1'b1;
        end
      end
      lhs_pkg::StReply: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = lhs_pkg::SlotFieldW'(res_slot_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhs_pkg::StClear;
      pos_q       <= '0;
      probe_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      probe_q     <= probe_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    kind_q       <= kind_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign key_o       = key_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb_linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_set
// Self-checking bench for the linear-probing hash set. A scoreboard keeps its
// own copy of the slot table and predicts the reply to every accepted insert
// or find. Directed items cover the edges first. Random traffic then fills the
// table until inserts are refused; both channels stall at random till the last third.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_probe_hash_set;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 1250;
  localparam int DrainCycles = 20;

  typedef struct packed {
    lhs_pkg::lhs_status_e           status;
    logic [lhs_pkg::SlotFieldW-1:0] slot;
  } reply_t;

  // Mirrors the slot table and queues the reply each request should produce.
  class probe_scoreboard;
    logic [lhs_pkg::KeyW-1:0] slot_keys [lhs_pkg::TableSlots];
    int unsigned              stored;
    reply_t                   replies_due [$];
    int unsigned              errors;

    function new();
      foreach (slot_keys[i]) slot_keys[i] = '0;
      stored = 0;
      errors = 0;
    endfunction

    function void note_request(lhs_pkg::lhs_kind_e kind, logic [lhs_pkg::KeyW-1:0] key);
      int unsigned pos;
      reply_t      r;
      r.status = lhs_pkg::StatNotFound;
      r.slot   = '0;
      pos      = int'(key % lhs_pkg::TableSlots);
      if (key == '0) begin
        r.status = lhs_pkg::StatReserved;
      end else if (kind == lhs_pkg::KindInsert) begin
        // One slot always stays empty, so the probe below always ends.
        if (stored + 1 >= lhs_pkg::TableSlots) begin
          r.status = lhs_pkg::StatFull;
        end else begin
          while (slot_keys[pos] != '0) pos = (pos + 1) % lhs_pkg::TableSlots;
          slot_keys[pos] = key;
          stored++;
          r.status = lhs_pkg::StatInserted;
          r.slot   = lhs_pkg::SlotFieldW'(pos);
        end
      end else begin
        for (int n = 0; n < lhs_pkg::TableSlots; n++) begin
          if (slot_keys[pos] == key) begin
            r.status = lhs_pkg::StatFound;
            r.slot   = lhs_pkg::SlotFieldW'(pos);
            break;
          end
          if (slot_keys[pos] == '0) break;
          pos = (pos + 1) % lhs_pkg::TableSlots;
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [lhs_pkg::StatusW-1:0]    status,
                              logic [lhs_pkg::SlotFieldW-1:0] slot);
      reply_t due;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, expected none, actual status %0d slot %0d",
                 $time, status, slot);
        return;
      end
      due = replies_due.pop_front();
      if (status !== due.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, due.status, status);
      end
      if (slot !== due.slot) begin
        errors++;
        $display("%0t: slot mismatch, expected %0d, actual %0d", $time, due.slot, slot);
      end
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  logic                            kind_i      = 1'b0;
  logic [lhs_pkg::KeyW-1:0]        key_i       = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [lhs_pkg::StatusW-1:0]     status_o;
  logic [lhs_pkg::SlotFieldW-1:0]  slot_o;

  int unsigned              src_idle_pct  = 37;
  int unsigned              sink_idle_pct = 46;
  logic [lhs_pkg::KeyW-1:0] stored_keys [$];
  probe_scoreboard          book = new();

  linear_probe_hash_set dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .slot_o      (slot_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Reply side: check what was accepted at this edge, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) book.check_reply(status_o, slot_o);
    out_ready_i <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Valid is only lowered during an idle cycle, so back-to-back items keep it high.
  task automatic send_item(lhs_pkg::lhs_kind_e kind, logic [lhs_pkg::KeyW-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_request(kind, key);
    if (kind == lhs_pkg::KindInsert && key != '0) stored_keys.push_back(key);
  endtask

  // Some keys get home slots near the wrap point to build long clusters there.
  function automatic logic [lhs_pkg::KeyW-1:0] fresh_key();
    logic [lhs_pkg::KeyW-1:0] k;
    k = {$urandom, $urandom};
    if ($urandom_range(99) < 20) begin
      k[lhs_pkg::SlotW-1:0] = lhs_pkg::SlotW'((lhs_pkg::TableSlots - 8 + $urandom_range(15))
                                              % lhs_pkg::TableSlots);
    end
    if (k == '0) k = 64'd1;
    return k;
  endfunction

  function automatic logic [lhs_pkg::KeyW-1:0] known_key();
    if (stored_keys.size() == 0) return fresh_key();
    return stored_keys[$urandom_range(stored_keys.size() - 1)];
  endfunction

  initial begin
    int unsigned              roll;
    lhs_pkg::lhs_kind_e       kind;
    logic [lhs_pkg::KeyW-1:0] key;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: reserved key, empty table, wrap past the last slot,
    // duplicates and collisions on the home slot at the wrap point.
    send_item(lhs_pkg::KindInsert, '0);
    send_item(lhs_pkg::KindFind, '0);
    send_item(lhs_pkg::KindFind, 64'd1);
    send_item(lhs_pkg::KindInsert, 64'd1);
    send_item(lhs_pkg::KindInsert, '1);
    send_item(lhs_pkg::KindInsert, '1);
    send_item(lhs_pkg::KindFind, '1);
    send_item(lhs_pkg::KindInsert, 64'd1024);
    send_item(lhs_pkg::KindFind, 64'd1024);
    send_item(lhs_pkg::KindFind, 64'd2048);
    send_item(lhs_pkg::KindInsert, 64'h8000_0000_0000_0000);
    send_item(lhs_pkg::KindInsert, 64'h7FFF_FFFF_FFFF_FC00);
    send_item(lhs_pkg::KindFind, 64'h8000_0000_0000_0000);
    send_item(lhs_pkg::KindInsert, 64'h0000_0000_0000_03FF);
    send_item(lhs_pkg::KindFind, 64'h0000_0000_0000_03FF);
    send_item(lhs_pkg::KindFind, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(lhs_pkg::KindInsert, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(lhs_pkg::KindInsert, 64'h5555_5555_5555_5555);
    send_item(lhs_pkg::KindFind, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(lhs_pkg::KindFind, 64'h5555_5555_5555_5555);
    send_item(lhs_pkg::KindFind, 64'h7FFF_FFFF_FFFF_FC00);

    // Mostly inserts, so the table fills up and later inserts are refused.
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 3) begin
        src_idle_pct  = 46;
        sink_idle_pct = 37;
      end
      if (i == 2 * RandomItems / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 2) begin
        kind = lhs_pkg::lhs_kind_e'($urandom_range(1));
        key  = '0;
      end else if (roll < 88) begin
        kind = lhs_pkg::KindInsert;
        key  = ($urandom_range(99) < 15) ? known_key() : fresh_key();
      end else begin
        kind = lhs_pkg::KindFind;
        key  = ($urandom_range(99) < 60) ? known_key() : fresh_key();
      end
      send_item(kind, key);
    end
    in_valid_i <= 1'b0;

    while (book.replies_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (book.errors == 0 && book.replies_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

FILE: linear_probe_hash_set.f
sv/lhs_pkg.sv
sv/lhs_ram.sv
sv/lhs_cmp.sv
sv/lhs_ctrl.sv
sv/linear_probe_hash_set.sv
tb/sv/tb_linear_probe_hash_set.sv
